/* design/pht_pkg.sv */
// ----------------------------------------------------------------------------
// pht_pkg
// Shared types and codes for the per-owner handle table.
// ----------------------------------------------------------------------------
package pht_pkg;

  localparam int TABLE_ENTRIES_DEF = 64;
  localparam int HANDLE_LIMIT_DEF  = 64;

  localparam int MODE_W   = 2;
  localparam int TASK_W   = 8;
  localparam int HANDLE_W = 6;
  localparam int STATUS_W = 3;
  localparam int SLOT_W   = 6;

  // Largest handle the handle fields can carry.
  localparam int HANDLE_SPACE = 1 << HANDLE_W;
  localparam int HANDLE_MAX   = HANDLE_SPACE - 1;

  typedef enum logic [MODE_W-1:0] {
    MODE_ALLOC    = 2'd0,
    MODE_ALLOC_AT = 2'd1,
    MODE_GET      = 2'd2,
    MODE_DELETE   = 2'd3
  } mode_t;

  typedef enum logic [STATUS_W-1:0] {
    STAT_OK        = 3'd0,
    STAT_NOT_FOUND = 3'd1,
    STAT_NO_HANDLE = 3'd2,
    STAT_FULL      = 3'd3,
    STAT_PRESENT   = 3'd4
  } status_t;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_SCAN,
    S_HSCAN,
    S_FINISH
  } state_t;

  typedef struct packed {
    logic [MODE_W-1:0]   mode;
    logic [TASK_W-1:0]   task_id;
    logic [HANDLE_W-1:0] handle_in;
  } req_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [HANDLE_W-1:0] handle_out;
    logic [SLOT_W-1:0]   slot;
  } rsp_t;

  // One table entry as stored in the entry memory.
  typedef struct packed {
    logic                valid;
    logic [TASK_W-1:0]   owner;
    logic [HANDLE_W-1:0] handle;
  } entry_t;

endpackage

/* design/pht_entry_ram.sv */
// ----------------------------------------------------------------------------
// pht_entry_ram
// Single-write, single-read entry memory with registered read data.
// ----------------------------------------------------------------------------
module pht_entry_ram
  import pht_pkg::*;
#(
  parameter int DEPTH = TABLE_ENTRIES_DEF,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic          clk,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  entry_t        wr_data,
  input  logic          rd_en,
  input  logic [AW-1:0] rd_addr,
  output entry_t        rd_data
);

  entry_t mem [DEPTH];
  entry_t rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

/* design/per_owner_handle_table_core.sv */
// ----------------------------------------------------------------------------
// per_owner_handle_table_core
// Session table keyed by owner task and handle: allocate, allocate-at, get
// and delete, each resolved by a sequential scan over the entry memory.
// ----------------------------------------------------------------------------
// Usage:
//   Drive in_item and raise start; a request transfers at the clock edge where
//   start is high and busy is low. busy stays high until the request is done.
//   Each request yields exactly one result, shown on out_item for one cycle
//   with out_valid high. The receiver cannot stall; take the result then.
// Operation (H = min(HANDLE_LIMIT-1, 63), the highest handle allocate hands out):
//   get, delete and allocate-at: one pass over the entry memory, one entry
//   per cycle through its single read port.
//   allocate: the same pass builds a bitmap of handles the task holds, then
//   probes that bitmap one handle per cycle from 1 upward, up to handle H.
//   A new request may transfer in the cycle that shows the previous result.
// Reset:
//   rst_n low (synchronous) restarts a clearing pass that writes every entry
//   invalid, one per cycle; busy is high for the whole pass after reset.
// ----------------------------------------------------------------------------
module per_owner_handle_table_core
  import pht_pkg::*;
#(
  parameter int TABLE_ENTRIES = TABLE_ENTRIES_DEF,
  parameter int HANDLE_LIMIT  = HANDLE_LIMIT_DEF
) (
  input  logic clk,
  input  logic rst_n,
  input  logic start,
  output logic busy,
  input  req_t in_item,
  output logic out_valid,
  output rsp_t out_item
);

  localparam int IDXW = $clog2(TABLE_ENTRIES);
  localparam int AW   = IDXW + 1;
  localparam logic [AW-1:0]   ENTRY_CNT = AW'(TABLE_ENTRIES);
  localparam logic [IDXW-1:0] LAST_IDX  = IDXW'(TABLE_ENTRIES - 1);
  // Highest handle that allocate may hand out.
  localparam int HTOP = (HANDLE_LIMIT - 1 > HANDLE_MAX) ? HANDLE_MAX : HANDLE_LIMIT - 1;
  localparam logic [HANDLE_W-1:0] HTOP_H = HANDLE_W'(HTOP);

  state_t                  state_r, state_nxt;
  logic [AW-1:0]           addr_r, addr_nxt;
  logic                    pipe_vld_r, pipe_vld_nxt;
  logic [IDXW-1:0]         pipe_idx_r, pipe_idx_nxt;
  req_t                    req_r, req_nxt;
  logic [HANDLE_W-1:0]     op_handle_r, op_handle_nxt;
  logic                    found_r, found_nxt;
  logic [IDXW-1:0]         match_idx_r, match_idx_nxt;
  logic                    free_found_r, free_found_nxt;
  logic [IDXW-1:0]         free_idx_r, free_idx_nxt;
  logic [HANDLE_SPACE-1:0] held_r, held_nxt;
  logic [HANDLE_W-1:0]     h_r, h_nxt;
  logic                    no_handle_r, no_handle_nxt;
  logic                    out_valid_r, out_valid_nxt;
  rsp_t                    out_r, out_nxt;

  logic            ram_wr_en;
  logic [IDXW-1:0] ram_wr_addr;
  entry_t          ram_wr_data;
  logic            ram_rd_en;
  entry_t          ram_rd_data;

  logic owner_hit;
  logic pair_hit;
  logic accept;

  // Zero-extend or truncate an entry index to the slot field.
  logic [SLOT_W+IDXW-1:0] match_ext, free_ext;
  assign match_ext = {{SLOT_W{1'b0}}, match_idx_r};
  assign free_ext  = {{SLOT_W{1'b0}}, free_idx_r};

  pht_entry_ram #(
    .DEPTH (TABLE_ENTRIES),
    .AW    (IDXW)
  ) u_ram (
    .clk     (clk),
    .wr_en   (ram_wr_en),
    .wr_addr (ram_wr_addr),
    .wr_data (ram_wr_data),
    .rd_en   (ram_rd_en),
    .rd_addr (addr_r[IDXW-1:0]),
    .rd_data (ram_rd_data)
  );

  assign busy      = (state_r != S_IDLE);
  assign accept    = start && !busy;
  assign out_valid = out_valid_r;
  assign out_item  = out_r;

  // Compare the entry coming back from memory against the request.
  assign owner_hit = ram_rd_data.valid && (ram_rd_data.owner == req_r.task_id);
  assign pair_hit  = owner_hit && (ram_rd_data.handle == req_r.handle_in);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      addr_r      <= '0;
      pipe_vld_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      addr_r      <= addr_nxt;
      pipe_vld_r  <= pipe_vld_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pipe_idx_r   <= pipe_idx_nxt;
    req_r        <= req_nxt;
    op_handle_r  <= op_handle_nxt;
    found_r      <= found_nxt;
    match_idx_r  <= match_idx_nxt;
    free_found_r <= free_found_nxt;
    free_idx_r   <= free_idx_nxt;
    held_r       <= held_nxt;
    h_r          <= h_nxt;
    no_handle_r  <= no_handle_nxt;
    out_r        <= out_nxt;
  end

  always_comb begin
    state_nxt      = state_r;
    addr_nxt       = addr_r;
    pipe_vld_nxt   = 1'b0;
    pipe_idx_nxt   = addr_r[IDXW-1:0];
    req_nxt        = req_r;
    op_handle_nxt  = op_handle_r;
    found_nxt      = found_r;
    match_idx_nxt  = match_idx_r;
    free_found_nxt = free_found_r;
    free_idx_nxt   = free_idx_r;
    held_nxt       = held_r;
    h_nxt          = h_r;
    no_handle_nxt  = no_handle_r;
    out_valid_nxt  = 1'b0;
    out_nxt        = out_r;
    ram_wr_en      = 1'b0;
    ram_wr_addr    = pipe_idx_r;
    ram_wr_data    = '0;
    ram_rd_en      = 1'b0;

    case (state_r)
      S_CLEAR: begin
        // Sweep every entry to invalid after reset.
        ram_wr_en   = 1'b1;
        ram_wr_addr = addr_r[IDXW-1:0];
        addr_nxt    = addr_r + AW'(1);
        if (addr_r[IDXW-1:0] == LAST_IDX) begin
          state_nxt = S_IDLE;
        end
      end

      S_IDLE: begin
        if (accept) begin
          req_nxt        = in_item;
          op_handle_nxt  = in_item.handle_in;
          found_nxt      = 1'b0;
          free_found_nxt = 1'b0;
          held_nxt       = '0;
          no_handle_nxt  = 1'b0;
          h_nxt          = HANDLE_W'(1);
          addr_nxt       = '0;
          state_nxt      = S_SCAN;
        end
      end

      S_SCAN: begin
        // Issue one read per cycle; process the entry read last cycle.
        ram_rd_en    = (addr_r != ENTRY_CNT);
        pipe_vld_nxt = ram_rd_en;
        if (ram_rd_en) begin
          addr_nxt = addr_r + AW'(1);
        end
        if (pipe_vld_r) begin
          if (owner_hit) begin
            held_nxt[ram_rd_data.handle] = 1'b1;
          end
          if (pair_hit && !found_r) begin
            found_nxt     = 1'b1;
            match_idx_nxt = pipe_idx_r;
          end
          if (!ram_rd_data.valid && !free_found_r) begin
            free_found_nxt = 1'b1;
            free_idx_nxt   = pipe_idx_r;
          end
          // Delete drops every matching entry as the scan passes it.
          if (pair_hit && (req_r.mode == MODE_DELETE)) begin
            ram_wr_en = 1'b1;
          end
        end
        if (!ram_rd_en && !pipe_vld_r) begin
          state_nxt = (req_r.mode == MODE_ALLOC) ? S_HSCAN : S_FINISH;
        end
      end

      S_HSCAN: begin
        // Probe the held bitmap from handle 1 upward.
        if (!held_r[h_r]) begin
          op_handle_nxt = h_r;
          state_nxt     = S_FINISH;
        end else if (h_r == HTOP_H) begin
          no_handle_nxt = 1'b1;
          state_nxt     = S_FINISH;
        end else begin
          h_nxt = h_r + HANDLE_W'(1);
        end
      end

      S_FINISH: begin
        out_valid_nxt = 1'b1;
        state_nxt     = S_IDLE;
        ram_wr_data   = '{valid: 1'b1, owner: req_r.task_id, handle: op_handle_r};
        ram_wr_addr   = free_idx_r;
        out_nxt       = '{status: STAT_OK, handle_out: op_handle_r,
                          slot: match_ext[SLOT_W-1:0]};
        case (req_r.mode)
          MODE_ALLOC, MODE_ALLOC_AT: begin
            if ((req_r.mode == MODE_ALLOC) && no_handle_r) begin
              out_nxt = '{status: STAT_NO_HANDLE, handle_out: '0, slot: '0};
            end else if ((req_r.mode == MODE_ALLOC_AT) && found_r) begin
              out_nxt.status = STAT_PRESENT;
            end else if (!free_found_r) begin
              out_nxt = '{status: STAT_FULL, handle_out: '0, slot: '0};
            end else begin
              ram_wr_en    = 1'b1;
              out_nxt.slot = free_ext[SLOT_W-1:0];
            end
          end
          default: begin
            if (!found_r) begin
              out_nxt = '{status: STAT_NOT_FOUND, handle_out: '0, slot: '0};
            end
          end
        endcase
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // A result strobe never lasts more than one cycle.
  a_strobe_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result strobe held for two cycles");

  // Each finish step of a request is followed by a result strobe.
  a_strobe_after_finish: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_FINISH) |=> out_valid)
    else $error("finish step without result strobe");

  // Writes during the scan come only from a delete.
  a_scan_write_delete: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SCAN) && ram_wr_en |-> (req_r.mode == MODE_DELETE))
    else $error("entry written during scan by a non-delete request");

  // A successful allocate never hands out handle zero.
  a_alloc_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (req_r.mode == MODE_ALLOC) && (out_item.status == STAT_OK)
      |-> (out_item.handle_out != '0))
    else $error("allocate returned handle zero");

  // No request transfers while the clearing pass runs.
  a_clear_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_CLEAR) |-> busy)
    else $error("ready during clearing pass");

endmodule
